[src/rtgg_pkg.sv]
package rtgg_pkg;

   // Fixed widths of the configuration registers and result fields.
   localparam int LIMIT_BITS     = 32;
   localparam int CAP_BITS       = 7;
   localparam int GRID_BITS      = 6;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = LIMIT_BITS;

   // Defaults for the top-level parameters.
   localparam int DIM_BITS_DEFAULT  = 24;
   localparam int MAX_TILES_DEFAULT = 64;

   // Register reset values.
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 32'd16777216;
   localparam logic [CAP_BITS-1:0]   CAP_RESET   = 7'd64;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_PIXELS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_TILES  = 1'd1;

   // Operand selection for the shared divider.
   typedef logic [1:0] div_sel_type;
   localparam div_sel_type DIV_SEL_COLS  = 2'd0;
   localparam div_sel_type DIV_SEL_CELLW = 2'd1;
   localparam div_sel_type DIV_SEL_CELLH = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        prod;
      logic        tile_step;
      logic        row_init;
      logic        row_step;
      logic        div_start;
      logic        div_store;
      div_sel_type div_sel;
      logic        emit_init;
      logic        emit_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic dim_zero;
      logic tile_done;
      logic row_done;
      logic div_done;
      logic last;
   } status_type;

endpackage

[src/rtgg_div.sv]
module rtgg_div import rtgg_pkg::*; #(
   parameter int DIVIDEND_BITS = DIM_BITS_DEFAULT + 1,
   parameter int DIVISOR_BITS  = $clog2(MAX_TILES_DEFAULT + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dsr_ff, dsr_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;

   // One quotient bit per cycle, restoring division, most significant bit first.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = (trial >= {1'b0, dsr_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_BITS'(DIVIDEND_BITS);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[src/rtgg_dp.sv]
module rtgg_dp import rtgg_pkg::*; #(
   parameter int MAX_TILES = MAX_TILES_DEFAULT,
   parameter int DIM_BITS  = DIM_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cmd_type                              cmd,
   output status_type                           status,
   input  logic [LIMIT_BITS-1:0]                limit,
   input  logic [$clog2(MAX_TILES + 1)-1:0]     cap,
   input  logic [DIM_BITS-1:0]                  req_raster_width,
   input  logic [DIM_BITS-1:0]                  req_raster_height,
   output logic [DIM_BITS-1:0]                  rsp_x_offset,
   output logic [DIM_BITS-1:0]                  rsp_y_offset,
   output logic [DIM_BITS-1:0]                  rsp_x_size,
   output logic [DIM_BITS-1:0]                  rsp_y_size,
   output logic [GRID_BITS-1:0]                 rsp_grid_row,
   output logic [GRID_BITS-1:0]                 rsp_grid_col
);

   localparam int TCW       = $clog2(MAX_TILES + 1);
   localparam int PROD_BITS = 2 * DIM_BITS;
   localparam int ACC_BITS  = LIMIT_BITS + TCW;
   localparam int CMP_BITS  = (PROD_BITS > ACC_BITS) ? PROD_BITS : ACC_BITS;
   localparam int BND_BITS  = DIM_BITS + TCW + 2;
   localparam int SQ_BITS   = DIM_BITS + 2 * TCW + 2;
   localparam int DW        = DIM_BITS + 1;

   logic [DIM_BITS-1:0]  w_ff, w_in, h_ff, h_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [ACC_BITS-1:0]  acc_ff, acc_in;
   logic [TCW-1:0]       t_ff, t_in;
   logic [BND_BITS-1:0]  bound_ff, bound_in;
   logic [SQ_BITS-1:0]   sq_ff, sq_in, inc_ff, inc_in;
   logic [TCW:0]         k_ff, k_in;
   logic [TCW-1:0]       rows_ff, rows_in, cols_ff, cols_in;
   logic [DIM_BITS-1:0]  cell_w_ff, cell_w_in, cell_h_ff, cell_h_in;
   logic [DIM_BITS-1:0]  xoff_ff, xoff_in, yoff_ff, yoff_in;
   logic [TCW-1:0]       row_ff, row_in, col_ff, col_in;

   logic [DW-1:0]        div_dividend;
   logic [TCW-1:0]       div_divisor;
   logic                 div_done;
   logic [DW-1:0]        div_quotient;
   logic [DIM_BITS:0]    next_x, next_y;
   logic [DIM_BITS-1:0]  x_left, y_left;
   logic                 more_col, more_row;

   // Operands of the shared divider; the ceiling forms add divisor minus one.
   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_CELLW: begin
            div_dividend = DW'(w_ff) + DW'(cols_ff) - DW'(1);
            div_divisor  = cols_ff;
         end
         DIV_SEL_CELLH: begin
            div_dividend = DW'(h_ff) + DW'(rows_ff) - DW'(1);
            div_divisor  = rows_ff;
         end
         default: begin
            div_dividend = DW'(t_ff);
            div_divisor  = rows_ff;
         end
      endcase
   end

   rtgg_div #(
      .DIVIDEND_BITS (DW),
      .DIVISOR_BITS  (TCW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Window walk: step along the row, else drop to the next row.
   always_comb begin
      next_x   = {1'b0, xoff_ff} + {1'b0, cell_w_ff};
      next_y   = {1'b0, yoff_ff} + {1'b0, cell_h_ff};
      more_col = (col_ff + 1'b1 < cols_ff) && (next_x < {1'b0, w_ff});
      more_row = (row_ff + 1'b1 < rows_ff) && (next_y < {1'b0, h_ff});
      x_left   = w_ff - xoff_ff;
      y_left   = h_ff - yoff_ff;
   end

   // Next values of the datapath registers under the controller's commands.
   always_comb begin
      w_in      = w_ff;
      h_in      = h_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      t_in      = t_ff;
      bound_in  = bound_ff;
      sq_in     = sq_ff;
      inc_in    = inc_ff;
      k_in      = k_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      cell_w_in = cell_w_ff;
      cell_h_in = cell_h_ff;
      xoff_in   = xoff_ff;
      yoff_in   = yoff_ff;
      row_in    = row_ff;
      col_in    = col_ff;

      if (cmd.load) begin
         w_in = req_raster_width;
         h_in = req_raster_height;
      end

      // Tile count: smallest t with t * limit covering the pixel count, or the cap if reached first.
      if (cmd.prod) begin
         prod_in = PROD_BITS'(w_ff) * PROD_BITS'(h_ff);
         acc_in  = ACC_BITS'(limit);
         t_in    = TCW'(1);
      end
      if (cmd.tile_step) begin
         acc_in = acc_ff + ACC_BITS'(limit);
         t_in   = t_ff + 1'b1;
      end

      // Row count: (2k-1)^2 * W grows by 8k * W from one k to the next.
      if (cmd.row_init) begin
         bound_in = (BND_BITS'(t_ff) * BND_BITS'(h_ff)) << 2;
         sq_in    = SQ_BITS'(w_ff);
         inc_in   = SQ_BITS'(w_ff) << 3;
         k_in     = (TCW + 1)'(1);
         rows_in  = TCW'(1);
      end
      if (cmd.row_step) begin
         rows_in = k_ff[TCW-1:0];
         k_in    = k_ff + 1'b1;
         sq_in   = sq_ff + inc_ff;
         inc_in  = inc_ff + (SQ_BITS'(w_ff) << 3);
      end

      if (cmd.div_store) begin
         case (cmd.div_sel)
            DIV_SEL_CELLW: cell_w_in = div_quotient[DIM_BITS-1:0];
            DIV_SEL_CELLH: cell_h_in = div_quotient[DIM_BITS-1:0];
            default:       cols_in   = div_quotient[TCW-1:0];
         endcase
      end

      if (cmd.emit_init) begin
         xoff_in = '0;
         yoff_in = '0;
         row_in  = '0;
         col_in  = '0;
      end
      if (cmd.emit_step) begin
         if (more_col) begin
            col_in  = col_ff + 1'b1;
            xoff_in = next_x[DIM_BITS-1:0];
         end else begin
            row_in  = row_ff + 1'b1;
            col_in  = '0;
            xoff_in = '0;
            yoff_in = next_y[DIM_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      h_ff      <= h_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      t_ff      <= t_in;
      bound_ff  <= bound_in;
      sq_ff     <= sq_in;
      inc_ff    <= inc_in;
      k_ff      <= k_in;
      rows_ff   <= rows_in;
      cols_ff   <= cols_in;
      cell_w_ff <= cell_w_in;
      cell_h_ff <= cell_h_in;
      xoff_ff   <= xoff_in;
      yoff_ff   <= yoff_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
   end

   // Status back to the controller.
   always_comb begin
      status.dim_zero  = (w_ff == '0) || (h_ff == '0);
      status.tile_done = (CMP_BITS'(acc_ff) >= CMP_BITS'(prod_ff)) || (t_ff == cap);
      status.row_done  = (k_ff > {1'b0, t_ff}) || (sq_ff > SQ_BITS'(bound_ff));
      status.div_done  = div_done;
      status.last      = !more_col && !more_row;
   end

   // Result payload, held steady while the controller waits on the consumer.
   assign rsp_x_offset = xoff_ff;
   assign rsp_y_offset = yoff_ff;
   assign rsp_x_size   = (x_left < cell_w_ff) ? x_left : cell_w_ff;
   assign rsp_y_size   = (y_left < cell_h_ff) ? y_left : cell_h_ff;
   assign rsp_grid_row = GRID_BITS'(row_ff);
   assign rsp_grid_col = GRID_BITS'(col_ff);

endmodule

[src/rtgg_ctrl.sv]
module rtgg_ctrl import rtgg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_PROD     = 4'd1;
   localparam logic [3:0] ST_TILES    = 4'd2;
   localparam logic [3:0] ST_ROW_INIT = 4'd3;
   localparam logic [3:0] ST_ROWS     = 4'd4;
   localparam logic [3:0] ST_COLS_GO  = 4'd5;
   localparam logic [3:0] ST_COLS_WT  = 4'd6;
   localparam logic [3:0] ST_CW_GO    = 4'd7;
   localparam logic [3:0] ST_CW_WT    = 4'd8;
   localparam logic [3:0] ST_CH_GO    = 4'd9;
   localparam logic [3:0] ST_CH_WT    = 4'd10;
   localparam logic [3:0] ST_EMIT     = 4'd11;

   logic [3:0] state_ff, state_in;

   // Sequencing of one raster: tile count, row count, three divisions, windows; a zero dimension returns to idle.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.div_sel = DIV_SEL_COLS;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            if (status.dim_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.prod = 1'b1;
               state_in = ST_TILES;
            end
         end
         ST_TILES: begin
            if (status.tile_done) begin
               state_in = ST_ROW_INIT;
            end else begin
               cmd.tile_step = 1'b1;
            end
         end
         ST_ROW_INIT: begin
            cmd.row_init = 1'b1;
            state_in     = ST_ROWS;
         end
         ST_ROWS: begin
            if (status.row_done) begin
               state_in = ST_COLS_GO;
            end else begin
               cmd.row_step = 1'b1;
            end
         end
         ST_COLS_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_COLS_WT;
         end
         ST_COLS_WT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_CW_GO;
            end
         end
         ST_CW_GO: begin
            cmd.div_sel   = DIV_SEL_CELLW;
            cmd.div_start = 1'b1;
            state_in      = ST_CW_WT;
         end
         ST_CW_WT: begin
            cmd.div_sel = DIV_SEL_CELLW;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_CH_GO;
            end
         end
         ST_CH_GO: begin
            cmd.div_sel   = DIV_SEL_CELLH;
            cmd.div_start = 1'b1;
            state_in      = ST_CH_WT;
         end
         ST_CH_WT: begin
            cmd.div_sel = DIV_SEL_CELLH;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_step = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/raster_tile_grid_generator.sv]
// Channel     Ports                                  Direction  Transaction
// request     req_valid/req_ready, req_raster_*      in         one raster size
// response    rsp_valid/rsp_ready, rsp_*             out        one window
// csr         csr_wr_en, csr_index, csr_wdata        in         one register write
//
// A raster is taken only while the block is idle; its windows then follow.
// Setup runs a tile search of up to T steps, a row search of up to R + 1 steps and
// three passes of the one-bit-per-cycle divider. Windows then leave at one per cycle
// while the consumer is ready. Reset is synchronous and restores the register
// defaults; a stalled response holds its window until it is taken.
module raster_tile_grid_generator import rtgg_pkg::*; #(
   parameter int MAX_TILES = MAX_TILES_DEFAULT,
   parameter int DIM_BITS  = DIM_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [DIM_BITS-1:0]       req_raster_width,
   input  logic [DIM_BITS-1:0]       req_raster_height,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DIM_BITS-1:0]       rsp_x_offset,
   output logic [DIM_BITS-1:0]       rsp_y_offset,
   output logic [DIM_BITS-1:0]       rsp_x_size,
   output logic [DIM_BITS-1:0]       rsp_y_size,
   output logic [GRID_BITS-1:0]      rsp_grid_row,
   output logic [GRID_BITS-1:0]      rsp_grid_col,
   output logic                      rsp_last,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int TCW = $clog2(MAX_TILES + 1);

   logic [LIMIT_BITS-1:0] limit_ff;
   logic [CAP_BITS-1:0]   cap_ff;
   logic [LIMIT_BITS-1:0] limit_eff;
   logic [TCW-1:0]        cap_eff;
   cmd_type               cmd;
   status_type            status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         cap_ff   <= CAP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_PIXELS: limit_ff <= csr_wdata;
            CSR_MAX_TILES:  cap_ff   <= csr_wdata[CAP_BITS-1:0];
            default:        ;
         endcase
      end
   end

   // A zero limit counts as one; the tile cap is held to 1..MAX_TILES.
   always_comb begin
      limit_eff = (limit_ff == '0) ? LIMIT_BITS'(1) : limit_ff;
      if (cap_ff == '0) begin
         cap_eff = TCW'(1);
      end else if (cap_ff > CAP_BITS'(MAX_TILES)) begin
         cap_eff = TCW'(MAX_TILES);
      end else begin
         cap_eff = TCW'(cap_ff);
      end
   end

   rtgg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   rtgg_dp #(
      .MAX_TILES (MAX_TILES),
      .DIM_BITS  (DIM_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .limit             (limit_eff),
      .cap               (cap_eff),
      .req_raster_width  (req_raster_width),
      .req_raster_height (req_raster_height),
      .rsp_x_offset      (rsp_x_offset),
      .rsp_y_offset      (rsp_y_offset),
      .rsp_x_size        (rsp_x_size),
      .rsp_y_size        (rsp_y_size),
      .rsp_grid_row      (rsp_grid_row),
      .rsp_grid_col      (rsp_grid_col)
   );

   assign rsp_last = status.last;

endmodule
